>>> src/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, codes and constants of the seven-segment scan/blink unit.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned DIGIT_W    = $clog2(MAX_DIGITS);
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned NUMBER_W   = 27;
  localparam int unsigned PROD_W     = 55;

  localparam logic [7:0] BLANK_PATTERN = 8'hFF;

  // Exact reciprocals for num / 10^i with num < 2^27:
  // recip = ceil(2^(27+l) / 10^i), l = ceil(log2(10^i)), shift = 27+l.
  localparam int unsigned DEC_SHIFT [1:8] = '{31, 34, 37, 41, 44, 47, 51, 54};
  localparam logic [27:0] DEC_RECIP [1:8] = '{
    28'(((64'd1 << 31) + 64'd9) / 64'd10),
    28'(((64'd1 << 34) + 64'd99) / 64'd100),
    28'(((64'd1 << 37) + 64'd999) / 64'd1000),
    28'(((64'd1 << 41) + 64'd9999) / 64'd10000),
    28'(((64'd1 << 44) + 64'd99999) / 64'd100000),
    28'(((64'd1 << 47) + 64'd999999) / 64'd1000000),
    28'(((64'd1 << 51) + 64'd9999999) / 64'd10000000),
    28'(((64'd1 << 54) + 64'd99999999) / 64'd100000000)
  };

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_BLINK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_DIGIT_COUNT = 2'd0,
    CFG_SLOT_TICKS  = 2'd1,
    CFG_BLINK_EN    = 2'd2,
    CFG_BLINK_HALF  = 2'd3
  } cfg_reg_t;

  typedef logic [MAX_DIGITS-1:0][3:0] digit_vec_t;

  typedef struct packed {
    action_t    action;
    digit_vec_t digits;
    logic [7:0] blink_bits;
    logic       blink_on;
  } item_t;

  // active-low segments, common anode
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

endpackage

>>> src/seven_segment_scan_blink_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_blink_unit
// Multiplexed seven-segment driver: number set, blink mask and tick-driven scan.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, and a tick that produces
//   a result writes it to the output register. One input word per cycle
//   unless the output stalls; the decimal split sits before the input register,
//   state update and segment lookup between it and the output register.
// Reset (sync, rst_n low): registers to defaults, patterns blank, masks and
//   counters cleared, visibility all on; output and input stage empty.
module seven_segment_scan_blink_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // number[26:0], blink_bits[34:27], blink_on[35], zero
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // segments[7:0], digit_select[15:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ssb_pkg::*;

  // config
  logic [COUNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [7:0]         slot_ticks_r, slot_ticks_nxt;
  logic               blink_en_r, blink_en_nxt;
  logic [15:0]        blink_half_r, blink_half_nxt;

  // state
  logic [MAX_DIGITS-1:0][7:0] pat_r, pat_nxt;
  logic [MAX_DIGITS-1:0]      bmask_r, bmask_nxt;
  logic [MAX_DIGITS-1:0]      vis_r, vis_nxt;
  logic [MAX_DIGITS-1:0]      sweep_r, sweep_nxt;
  logic [DIGIT_W-1:0]         scan_r, scan_nxt;
  logic [7:0]                 slot_r, slot_nxt;
  logic [15:0]                bcnt_r, bcnt_nxt;

  // input stage and output register
  item_t       s1_r, s1_nxt;
  logic        s1_vld_r, s1_vld_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  digit_vec_t            split_digits;
  logic                  in_acc, advance, produced;
  logic [COUNT_W-1:0]    n_eff;
  logic [MAX_DIGITS-1:0] range_m, bmask_new;
  logic [15:0]           blim;
  logic [16:0]           bnext;
  logic [7:0]            slim;
  logic [8:0]            snext;
  logic [DIGIT_W-1:0]    sd;
  logic [COUNT_W-1:0]    sd_inc;

  ssb_digit_split u_split (
    .number (in_tdata[NUMBER_W-1:0]),
    .digits (split_digits)
  );

  assign cfg_ready  = 1'b1;
  assign advance    = s1_vld_r & (~out_vld_r | out_tready);
  assign in_tready  = ~s1_vld_r | advance;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (digit_count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (digit_count_r > COUNT_W'(MAX_DIGITS)) begin
      n_eff = COUNT_W'(MAX_DIGITS);
    end else begin
      n_eff = digit_count_r;
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      range_m[i] = (COUNT_W'(i) < n_eff);
    end
  end

  // config writes
  always_comb begin
    digit_count_nxt = digit_count_r;
    slot_ticks_nxt  = slot_ticks_r;
    blink_en_nxt    = blink_en_r;
    blink_half_nxt  = blink_half_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIGIT_COUNT: digit_count_nxt = cfg_data[COUNT_W-1:0];
        CFG_SLOT_TICKS:  slot_ticks_nxt  = cfg_data[7:0];
        CFG_BLINK_EN:    blink_en_nxt    = cfg_data[0];
        CFG_BLINK_HALF:  blink_half_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_comb begin
    s1_nxt     = s1_r;
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_nxt.action     = action_t'(in_tuser);
      s1_nxt.digits     = split_digits;
      s1_nxt.blink_bits = in_tdata[34:27];
      s1_nxt.blink_on   = in_tdata[35];
      s1_vld_nxt        = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // state update for the staged word
  always_comb begin
    pat_nxt      = pat_r;
    bmask_nxt    = bmask_r;
    vis_nxt      = vis_r;
    sweep_nxt    = sweep_r;
    scan_nxt     = scan_r;
    slot_nxt     = slot_r;
    bcnt_nxt     = bcnt_r;
    produced     = 1'b0;
    out_data_nxt = out_data_r;
    bmask_new    = s1_r.blink_on ? (bmask_r | s1_r.blink_bits)
                                 : (bmask_r & ~s1_r.blink_bits);
    blim         = (blink_half_r == '0) ? 16'd1 : blink_half_r;
    bnext        = {1'b0, bcnt_r} + 17'd1;
    slim         = (slot_ticks_r == '0) ? 8'd1 : slot_ticks_r;
    snext        = {1'b0, slot_r} + 9'd1;
    sd           = ({1'b0, scan_r} >= n_eff) ? '0 : scan_r;
    sd_inc       = {1'b0, sd} + COUNT_W'(1);

    if (advance) begin
      unique case (s1_r.action)
        ACT_SET: begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (range_m[i]) pat_nxt[i] = seg_pattern(s1_r.digits[i]);
          end
        end
        ACT_BLINK: begin
          bmask_nxt = bmask_new;
          if (bmask_r == '0 && bmask_new != '0) begin
            bcnt_nxt = '0;
          end else if (bmask_r != '0 && bmask_new == '0) begin
            bcnt_nxt = '0;
            vis_nxt  = '1;
          end
        end
        ACT_TICK: begin
          if (blink_en_r && bmask_r != '0) begin
            if (bnext >= {1'b0, blim}) begin
              bcnt_nxt = '0;
              vis_nxt  = vis_r ^ (bmask_r & range_m);
            end else begin
              bcnt_nxt = bnext[15:0];
            end
          end
          if (slot_r == '0) begin
            // visibility is latched at the start of each sweep
            if (sd == '0) sweep_nxt = vis_nxt;
            produced          = 1'b1;
            out_data_nxt[7:0] = sweep_nxt[sd] ? pat_r[sd] : BLANK_PATTERN;
            out_data_nxt[15:8] = 8'(MAX_DIGITS'(1) << sd);
          end
          if (snext >= {1'b0, slim}) begin
            slot_nxt = '0;
            scan_nxt = (sd_inc >= n_eff) ? '0 : sd_inc[DIGIT_W-1:0];
          end else begin
            slot_nxt = snext[7:0];
            // keep the wrapped position so a later count change starts at 0
            scan_nxt = sd;
          end
        end
        default: ;
      endcase
    end

    if (produced) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= COUNT_W'(MAX_DIGITS);
      slot_ticks_r  <= 8'd2;
      blink_en_r    <= 1'b0;
      blink_half_r  <= 16'd250;
      pat_r         <= {MAX_DIGITS{BLANK_PATTERN}};
      bmask_r       <= '0;
      vis_r         <= '1;
      sweep_r       <= '1;
      scan_r        <= '0;
      slot_r        <= '0;
      bcnt_r        <= '0;
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      digit_count_r <= digit_count_nxt;
      slot_ticks_r  <= slot_ticks_nxt;
      blink_en_r    <= blink_en_nxt;
      blink_half_r  <= blink_half_nxt;
      pat_r         <= pat_nxt;
      bmask_r       <= bmask_nxt;
      vis_r         <= vis_nxt;
      sweep_r       <= sweep_nxt;
      scan_r        <= scan_nxt;
      slot_r        <= slot_nxt;
      bcnt_r        <= bcnt_nxt;
      s1_vld_r      <= s1_vld_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> src/ssb_digit_split.sv
// ----------------------------------------------------------------------------
// ssb_digit_split
// Splits a number into its lowest decimal digits with parallel reciprocal
// multiplies; digit i = q(i) - 10*q(i+1), kept mod 16.
// ----------------------------------------------------------------------------
module ssb_digit_split (
  input  logic [ssb_pkg::NUMBER_W-1:0] number,
  output ssb_pkg::digit_vec_t          digits
);
  import ssb_pkg::*;

  logic [PROD_W-1:0] prod [1:MAX_DIGITS];
  logic [3:0]        qlo  [0:MAX_DIGITS];

  always_comb begin
    qlo[0] = number[3:0];
    for (int i = 1; i <= MAX_DIGITS; i++) begin
      prod[i] = PROD_W'(number) * PROD_W'(DEC_RECIP[i]);
      qlo[i]  = 4'(prod[i] >> DEC_SHIFT[i]);
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits[i] = 4'(qlo[i] - {qlo[i+1][0], 3'b000} - {qlo[i+1][2:0], 1'b0});
    end
  end

endmodule

>>> src/ssb_checker.sv
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks on the result stream of the scan/blink unit.
// ----------------------------------------------------------------------------
module ssb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // exactly one digit is driven per word
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[15:8]))
    else $error("digit select not one-hot");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind seven_segment_scan_blink_unit ssb_checker u_ssb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
